FILE: hdl/u8dse_pkg.sv
`timescale 1ns / 1ps

package u8dse_pkg;

    // lead byte ranges
    localparam logic [7:0] C_LEAD2_LO = 8'hC2;
    localparam logic [7:0] C_LEAD2_HI = 8'hDF;
    localparam logic [7:0] C_LEAD3_LO = 8'hE0;
    localparam logic [7:0] C_LEAD3_HI = 8'hEF;
    localparam logic [7:0] C_LEAD4_LO = 8'hF0;
    localparam logic [7:0] C_LEAD4_HI = 8'hF4;

    // code point limits
    localparam logic [20:0] C_MIN3      = 21'h000800;
    localparam logic [20:0] C_MIN4      = 21'h010000;
    localparam logic [20:0] C_MAX_CP    = 21'h10FFFF;
    localparam logic [20:0] C_SURR_LO   = 21'h00D800;
    localparam logic [20:0] C_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] C_ESC_BASE  = 21'h00DC00;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_ctl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic has_result;
        logic run_last;
        logic out_free;
    } t_ctl_sts;

    // outcome of decoding the head of the byte buffer
    typedef struct packed {
        logic        emit;
        logic [20:0] cp;
        logic        esc;
        logic [2:0]  consume;
    } t_dec;

    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] n;
        n = 3'd0;
        if (lead >= C_LEAD2_LO && lead <= C_LEAD2_HI) n = 3'd2;
        if (lead >= C_LEAD3_LO && lead <= C_LEAD3_HI) n = 3'd3;
        if (lead >= C_LEAD4_LO && lead <= C_LEAD4_HI) n = 3'd4;
        return n;
    endfunction

    // decode the sequence that starts at b0, with cnt bytes present
    function automatic t_dec decode(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [2:0] cnt,
        input logic       last
    );
        t_dec        d;
        logic [2:0]  n;
        logic        t1;
        logic        t2;
        logic        t3;
        logic        tails_ok;
        logic        in_range;
        logic [20:0] pt;
        n  = seq_len(b0);
        t1 = (b1[7:6] == 2'b10);
        t2 = (b2[7:6] == 2'b10);
        t3 = (b3[7:6] == 2'b10);
        // only tails that are present and belong to the sequence count
        tails_ok = (cnt < 3'd2 || t1)
                && (n < 3'd3 || cnt < 3'd3 || t2)
                && (n < 3'd4 || cnt < 3'd4 || t3);
        case (n)
            3'd2:    pt = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    pt = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    pt = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: pt = '0;
        endcase
        in_range = (n != 3'd3 || pt >= C_MIN3)
                && (n != 3'd4 || pt >= C_MIN4)
                && (pt <= C_MAX_CP)
                && !(pt >= C_SURR_LO && pt <= C_SURR_HI);
        // default: escape the lead byte
        d.emit    = 1'b1;
        d.cp      = C_ESC_BASE + {13'd0, b0};
        d.esc     = 1'b1;
        d.consume = 3'd1;
        if (cnt == 3'd0) begin
            d.emit    = 1'b0;
            d.consume = 3'd0;
        end else if (!b0[7]) begin
            d.cp  = {13'd0, b0};
            d.esc = 1'b0;
        end else if (n == 3'd0) begin
            d.esc = 1'b1;
        end else if (cnt < n) begin
            // valid prefix waits for more bytes unless the path ends
            if (tails_ok && !last) begin
                d.emit    = 1'b0;
                d.consume = 3'd0;
            end
        end else if (tails_ok && in_range) begin
            d.cp      = pt;
            d.esc     = 1'b0;
            d.consume = n;
        end
        return d;
    endfunction

endpackage

FILE: hdl/u8dse_ifs.sv
`timescale 1ns / 1ps

// byte channel into the decoder
interface u8dse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_path;

    modport source (output valid, output byte_in, output end_of_path, input ready);
    modport sink (input valid, input byte_in, input end_of_path, output ready);
endinterface

// code point channel out of the decoder
interface u8dse_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        escaped;
    logic        path_end;
    logic        last_of_run;

    modport source (
        output valid, output code_point, output escaped,
        output path_end, output last_of_run, input ready
    );
    modport sink (
        input valid, input code_point, input escaped,
        input path_end, input last_of_run, output ready
    );
endinterface

FILE: hdl/utf8_decode_surrogate_escape.sv
`timescale 1ns / 1ps

// Strict UTF-8 decoder for path bytes with surrogate escaping: each accepted
// byte (with an end-of-path flag) may release zero to four code points, and
// any lead byte that cannot start a valid sequence comes out as DC00 plus the
// byte with escaped set. A byte is loaded in the idle state; the scan state
// then emits the code points it releases one at a time, or goes straight
// back to idle when the byte only extends a pending sequence. The datapath
// decodes the buffer head with one decode call and the result after it with
// a second; it resolves one result per cycle while the output register is
// free, and a stalled output holds the scan. A new byte is taken while the
// last result still sits in the output register.
module utf8_decode_surrogate_escape
    import u8dse_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8dse_in_if.sink      i_in,
    u8dse_out_if.source   o_out
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    // sequencing of load and emit steps
    u8dse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // byte buffer, decoder and output register
    u8dse_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_byte        (i_in.byte_in),
        .i_end_of_path (i_in.end_of_path),
        .i_out_ready   (o_out.ready),
        .o_sts         (w_sts),
        .o_out_valid   (o_out.valid),
        .o_code_point  (o_out.code_point),
        .o_escaped     (o_out.escaped),
        .o_path_end    (o_out.path_end),
        .o_last_of_run (o_out.last_of_run)
    );

endmodule

FILE: hdl/u8dse_ctrl.sv
`timescale 1ns / 1ps

module u8dse_ctrl
    import u8dse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_ctl_sts i_sts,
    output logic     o_in_ready,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_sts.has_result) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.run_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/u8dse_dpath.sv
`timescale 1ns / 1ps

module u8dse_dpath
    import u8dse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl_cmd    i_cmd,
    input  logic [7:0]  i_byte,
    input  logic        i_end_of_path,
    input  logic        i_out_ready,
    output t_ctl_sts    o_sts,
    output logic        o_out_valid,
    output logic [20:0] o_code_point,
    output logic        o_escaped,
    output logic        o_path_end,
    output logic        o_last_of_run
);

    logic [7:0]  r_buf [4];
    logic [7:0]  n_buf [4];
    logic [2:0]  r_cnt;
    logic [2:0]  n_cnt;
    logic        r_last;
    logic        r_out_valid;
    logic [20:0] r_code_point;
    logic        r_escaped;
    logic        r_path_end;
    logic        r_last_of_run;
    logic [7:0]  w_sh [4];
    logic [2:0]  w_cnt1;
    t_dec        w_dec0;
    t_dec        w_dec1;

    // decode the head, then look one result ahead
    assign w_dec0 = decode(r_buf[0], r_buf[1], r_buf[2], r_buf[3], r_cnt, r_last);
    assign w_cnt1 = r_cnt - w_dec0.consume;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_sh[i] = r_buf[i];
        end
        case (w_dec0.consume)
            3'd1: begin
                w_sh[0] = r_buf[1];
                w_sh[1] = r_buf[2];
                w_sh[2] = r_buf[3];
            end
            3'd2: begin
                w_sh[0] = r_buf[2];
                w_sh[1] = r_buf[3];
            end
            3'd3: begin
                w_sh[0] = r_buf[3];
            end
            default: begin
            end
        endcase
    end

    assign w_dec1 = decode(w_sh[0], w_sh[1], w_sh[2], w_sh[3], w_cnt1, r_last);

    assign o_sts.has_result = w_dec0.emit;
    assign o_sts.run_last   = !w_dec1.emit;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // buffer: append on load, drop consumed bytes on step
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_buf[i] = r_buf[i];
        end
        n_cnt = r_cnt;
        if (i_cmd.load) begin
            n_buf[r_cnt[1:0]] = i_byte;
            n_cnt             = r_cnt + 3'd1;
        end else if (i_cmd.step) begin
            for (int i = 0; i < 4; i++) begin
                n_buf[i] = w_sh[i];
            end
            n_cnt = w_cnt1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_buf[i] <= n_buf[i];
        end
        if (i_cmd.load) begin
            r_last <= i_end_of_path;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_code_point  <= w_dec0.cp;
            r_escaped     <= w_dec0.esc;
            r_last_of_run <= !w_dec1.emit;
            r_path_end    <= !w_dec1.emit && r_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_point  = r_code_point;
    assign o_escaped     = r_escaped;
    assign o_path_end    = r_path_end;
    assign o_last_of_run = r_last_of_run;

`ifndef SYNTHESIS
    // at most three pending bytes plus the one just loaded
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("byte buffer count overflow");

    // a new byte only arrives when at most three are pending
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> r_cnt <= 3'd3)
        else $error("load into full buffer");

    // a step needs a result and a free output register
    a_step_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (w_dec0.emit && o_sts.out_free && !i_cmd.load))
        else $error("step without result or room");

    // the end of a path leaves nothing pending
    a_path_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !w_dec1.emit && r_last) |=> r_cnt == 3'd0)
        else $error("bytes left pending after path end");
`endif

endmodule
